/* rtl/core/swpb_pkg.sv */
// Shared types, constants and helpers of the sensor window peak band classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package swpb_pkg;

   localparam int HISTORY_DEPTH_DEF = 51;
   localparam int SAMPLE_W          = 10;
   localparam int INTERVAL_W        = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;

   localparam logic [SAMPLE_W-1:0]   FULL_SCALE     = 10'd1000;
   localparam logic [SAMPLE_W-1:0]   BAND_RESET     = 10'd50;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

   localparam logic [1:0] MODE_STORE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_GREY_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GREY_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BROWN_LEFT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BROWN_RIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_HALF   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL    = 3'd5;

   typedef struct packed {
      logic [1:0]          mode;
      logic [SAMPLE_W-1:0] left_sample;
      logic [SAMPLE_W-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic evaluated;
      logic grey_left_seen;
      logic grey_right_seen;
      logic brown_left_seen;
      logic brown_right_seen;
      logic black_left_seen;
      logic black_right_seen;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } pair_type;

   typedef struct packed {
      logic grey_l;
      logic grey_r;
      logic brown_l;
      logic brown_r;
      logic black_l;
      logic black_r;
   } flags_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   grey_left;
      logic [SAMPLE_W-1:0]   grey_right;
      logic [SAMPLE_W-1:0]   brown_left;
      logic [SAMPLE_W-1:0]   brown_right;
      logic [SAMPLE_W-1:0]   band_half;
      logic [INTERVAL_W-1:0] interval;
   } cfg_type;

   function automatic rsp_type make_rsp(input logic evaluated, input flags_type f);
      rsp_type r;
      r.evaluated        = evaluated;
      r.grey_left_seen   = f.grey_l;
      r.grey_right_seen  = f.grey_r;
      r.brown_left_seen  = f.brown_l;
      r.brown_right_seen = f.brown_r;
      r.black_left_seen  = f.black_l;
      r.black_right_seen = f.black_r;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/sensor_window_peak_band_classifier.sv */
// Sensor window peak band classifier: a row of HISTORY_DEPTH history cells, a band classifier
// and the control that sequences items. Depends on swpb_pkg, swpb_cell and swpb_eval.
//
// Every item gives one result. Store, clear, unused-mode and non-evaluating tick items may
// follow back to back. A tick that ends an interval starts a scan: a running peak travels
// down the row of cells, one cell per cycle, and no item is accepted until the scan is done.
// New sample pairs enter the head of the row and the oldest pair drops off the tail. A
// finished result waits in the output register; one more can wait in a pending register, and
// while it waits there no item is accepted.
`default_nettype none

module sensor_window_peak_band_classifier
   import swpb_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CW-1:0] SCAN_LAST = CW'(HISTORY_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_type;

   state_type             state_ff,    state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff,      rsp_in;
   rsp_type               pend_ff,     pend_in;
   flags_type             flags_ff,    flags_in;
   logic [INTERVAL_W-1:0] tick_cnt_ff, tick_cnt_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   cfg_type               cfg_ff;

   logic                  accept;
   logic                  out_free;
   logic                  shift_en;
   logic [INTERVAL_W-1:0] tick_inc;
   flags_type             flags_eval;
   flags_type             flags_item;
   rsp_type               result;
   logic                  finish;

   pair_type sample_chain [HISTORY_DEPTH+1];
   pair_type peak_chain   [HISTORY_DEPTH+1];

   assign sample_chain[0] = '{left: req_data.left_sample, right: req_data.right_sample};
   assign peak_chain[0]   = '0;

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      swpb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (shift_en),
         .sample_prev (sample_chain[g]),
         .sample_out  (sample_chain[g+1]),
         .peak_prev   (peak_chain[g]),
         .peak_out    (peak_chain[g+1])
      );
   end

   swpb_eval u_eval (
      .peak      (peak_chain[HISTORY_DEPTH]),
      .cfg       (cfg_ff),
      .flags_cur (flags_ff),
      .flags_new (flags_eval)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign shift_en  = accept && (req_data.mode == MODE_STORE);
   assign tick_inc  = (tick_cnt_ff == '1) ? tick_cnt_ff : tick_cnt_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grey_left   <= '0;
         cfg_ff.grey_right  <= '0;
         cfg_ff.brown_left  <= '0;
         cfg_ff.brown_right <= '0;
         cfg_ff.band_half   <= BAND_RESET;
         cfg_ff.interval    <= INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_GREY_LEFT:   cfg_ff.grey_left   <= csr_wdata[SAMPLE_W-1:0];
            REG_GREY_RIGHT:  cfg_ff.grey_right  <= csr_wdata[SAMPLE_W-1:0];
            REG_BROWN_LEFT:  cfg_ff.brown_left  <= csr_wdata[SAMPLE_W-1:0];
            REG_BROWN_RIGHT: cfg_ff.brown_right <= csr_wdata[SAMPLE_W-1:0];
            REG_BAND_HALF:   cfg_ff.band_half   <= csr_wdata[SAMPLE_W-1:0];
            REG_INTERVAL:    cfg_ff.interval    <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      flags_in     = flags_ff;
      tick_cnt_in  = tick_cnt_ff;
      scan_cnt_in  = scan_cnt_ff;
      flags_item   = flags_ff;
      finish       = 1'b0;
      result       = make_rsp(1'b0, flags_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               finish = 1'b1;
               case (req_data.mode)
                  MODE_TICK: begin
                     if (tick_inc >= cfg_ff.interval) begin
                        tick_cnt_in = '0;
                        scan_cnt_in = '0;
                        state_in    = ST_SCAN;
                        finish      = 1'b0;
                     end else begin
                        tick_cnt_in = tick_inc;
                     end
                  end
                  MODE_CLEAR: begin
                     flags_item = '0;
                     flags_in   = '0;
                  end
                  default: ;
               endcase
               result = make_rsp(1'b0, flags_item);
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == SCAN_LAST) begin
               flags_in = flags_eval;
               result   = make_rsp(1'b1, flags_eval);
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            pend_in  = result;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         tick_cnt_ff  <= '0;
         scan_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         tick_cnt_ff  <= tick_cnt_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= SCAN_LAST)
      else $error("scan counter past the end of the row");

   a_clear_flags: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.mode == MODE_CLEAR) |=> flags_ff == '0)
      else $error("clear item left flags set");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("pending item held with output register empty");

endmodule

`default_nettype wire

/* rtl/core/swpb_cell.sv */
// One history cell: holds a left/right sample pair and passes on a running peak.
// Depends on swpb_pkg.
`default_nettype none

module swpb_cell
   import swpb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     shift_en,
   input  wire pair_type sample_prev,
   output pair_type      sample_out,
   input  wire pair_type peak_prev,
   output pair_type      peak_out
);

   pair_type sample_ff;
   pair_type peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_prev;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff.left  <= (sample_ff.left  > peak_prev.left)  ? sample_ff.left  : peak_prev.left;
      peak_ff.right <= (sample_ff.right > peak_prev.right) ? sample_ff.right : peak_prev.right;
   end

   assign sample_out = sample_ff;
   assign peak_out   = peak_ff;

endmodule

`default_nettype wire

/* rtl/core/swpb_eval.sv */
// Band classifier: turns the two window peaks into updated seen flags.
// Depends on swpb_pkg.
`default_nettype none

module swpb_eval
   import swpb_pkg::*;
(
   input  wire pair_type  peak,
   input  wire cfg_type   cfg,
   input  wire flags_type flags_cur,
   output flags_type      flags_new
);

   function automatic logic in_band(input logic [SAMPLE_W-1:0] p,
                                    input logic [SAMPLE_W-1:0] r,
                                    input logic [SAMPLE_W-1:0] h);
      logic [SAMPLE_W:0] pe;
      logic [SAMPLE_W:0] re;
      logic [SAMPLE_W:0] he;
      pe = {1'b0, p};
      re = {1'b0, r};
      he = {1'b0, h};
      return (pe + he >= re) && (pe <= re + he);
   endfunction

   logic grey_l;
   logic grey_r;

   assign grey_l = in_band(peak.left,  cfg.grey_left,  cfg.band_half);
   assign grey_r = in_band(peak.right, cfg.grey_right, cfg.band_half);

   always_comb begin
      flags_new = flags_cur;
      if (peak.left == FULL_SCALE) begin
         flags_new.black_l = 1'b1;
      end
      if (peak.right == FULL_SCALE) begin
         flags_new.black_r = 1'b1;
      end else if (grey_l && grey_r) begin
         flags_new.grey_l = 1'b1;
         flags_new.grey_r = 1'b1;
      end else begin
         if (grey_l) begin
            flags_new.grey_l = 1'b1;
            flags_new.grey_r = 1'b0;
         end
         if (grey_r) begin
            flags_new.grey_r = 1'b1;
            flags_new.grey_l = 1'b0;
         end
         if (in_band(peak.left, cfg.brown_left, cfg.band_half)) begin
            flags_new.brown_l = 1'b1;
         end
         if (in_band(peak.right, cfg.brown_right, cfg.band_half)) begin
            flags_new.brown_r = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for sensor_window_peak_band_classifier: directed and random item streams, random
// idling on both channels, results checked against an in-bench model of the window and flags.
// Depends on swpb_pkg and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swpb_pkg::*;

   localparam logic [1:0]             MODE_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int DEPTH         = HISTORY_DEPTH_DEF;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [SAMPLE_W-1:0]   left_window [DEPTH];
   logic [SAMPLE_W-1:0]   right_window [DEPTH];
   int unsigned           next_slot;
   logic [INTERVAL_W-1:0] ticks_since_scan;
   flags_type             seen;
   cfg_type               cfg;
   rsp_type               reports_due [$];

   bit idling          = 1'b1;
   int errors          = 0;
   int items_sent      = 0;
   int reports_checked = 0;
   int scans_run       = 0;
   int csr_writes      = 0;
   int cycles          = 0;
   int stall_left      = 0;
   int tgt_left        = 0;
   int tgt_right       = 0;

   sensor_window_peak_band_classifier DUT (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void reset_model();
      foreach (left_window[k]) begin
         left_window[k]  = '0;
         right_window[k] = '0;
      end
      next_slot        = 0;
      ticks_since_scan = '0;
      seen             = '0;
      cfg              = '0;
      cfg.band_half    = BAND_RESET;
      cfg.interval     = INTERVAL_RESET;
   endfunction

   function automatic void set_reg(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_GREY_LEFT:   cfg.grey_left   = data[SAMPLE_W-1:0];
         REG_GREY_RIGHT:  cfg.grey_right  = data[SAMPLE_W-1:0];
         REG_BROWN_LEFT:  cfg.brown_left  = data[SAMPLE_W-1:0];
         REG_BROWN_RIGHT: cfg.brown_right = data[SAMPLE_W-1:0];
         REG_BAND_HALF:   cfg.band_half   = data[SAMPLE_W-1:0];
         REG_INTERVAL:    cfg.interval    = data;
         default: ;
      endcase
   endfunction

   function automatic bit in_band(input logic [SAMPLE_W-1:0] peak,
                                  input logic [SAMPLE_W-1:0] level);
      int p, r, h;
      p = peak;
      r = level;
      h = cfg.band_half;
      return p >= r - h && p <= r + h;
   endfunction

   function automatic void scan_window();
      logic [SAMPLE_W-1:0] pl, pr;
      bit gl, gr;
      pl = '0;
      pr = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (left_window[k] > pl) pl = left_window[k];
         if (right_window[k] > pr) pr = right_window[k];
      end
      scans_run++;
      if (pl == FULL_SCALE) seen.black_l = 1'b1;
      if (pr == FULL_SCALE) begin
         seen.black_r = 1'b1;
         return;
      end
      gl = in_band(pl, cfg.grey_left);
      gr = in_band(pr, cfg.grey_right);
      if (gl && gr) begin
         seen.grey_l = 1'b1;
         seen.grey_r = 1'b1;
         return;
      end
      if (gl) begin
         seen.grey_l = 1'b1;
         seen.grey_r = 1'b0;
      end
      if (gr) begin
         seen.grey_r = 1'b1;
         seen.grey_l = 1'b0;
      end
      if (in_band(pl, cfg.brown_left)) seen.brown_l = 1'b1;
      if (in_band(pr, cfg.brown_right)) seen.brown_r = 1'b1;
   endfunction

   function automatic void predict_report(input req_type it);
      rsp_type r;
      logic scanned;
      scanned = 1'b0;
      case (it.mode)
         MODE_STORE: begin
            left_window[next_slot]  = it.left_sample;
            right_window[next_slot] = it.right_sample;
            next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
         end
         MODE_TICK: begin
            if (ticks_since_scan != '1) ticks_since_scan++;
            if (ticks_since_scan >= cfg.interval) begin
               ticks_since_scan = '0;
               scan_window();
               scanned = 1'b1;
            end
         end
         MODE_CLEAR: seen = '0;
         default: ;
      endcase
      r.evaluated        = scanned;
      r.grey_left_seen   = seen.grey_l;
      r.grey_right_seen  = seen.grey_r;
      r.brown_left_seen  = seen.brown_l;
      r.brown_right_seen = seen.brown_r;
      r.black_left_seen  = seen.black_l;
      r.black_right_seen = seen.black_r;
      reports_due.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %b actual %b", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && req_ready) predict_report(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %p", $time, rsp_data);
         end else begin
            want = reports_due.pop_front();
            check_field("evaluated", want.evaluated, rsp_data.evaluated);
            check_field("grey_left_seen", want.grey_left_seen, rsp_data.grey_left_seen);
            check_field("grey_right_seen", want.grey_right_seen, rsp_data.grey_right_seen);
            check_field("brown_left_seen", want.brown_left_seen, rsp_data.brown_left_seen);
            check_field("brown_right_seen", want.brown_right_seen, rsp_data.brown_right_seen);
            check_field("black_left_seen", want.black_left_seen, rsp_data.black_left_seen);
            check_field("black_right_seen", want.black_right_seen, rsp_data.black_right_seen);
            reports_checked++;
         end
      end
   end

   // hold off the result channel in short random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] mode, input int ls, input int rs);
      req_type it;
      it.mode         = mode;
      it.left_sample  = ls[SAMPLE_W-1:0];
      it.right_sample = rs[SAMPLE_W-1:0];
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      set_reg(idx, data);
      csr_writes++;
   endtask

   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return FULL_SCALE;
         default: return $urandom_range(0, FULL_SCALE);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(input int value);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'(value);
      if ($urandom_range(0, 3) == 0) d[CSR_DATA_W-1:SAMPLE_W] = (CSR_DATA_W-SAMPLE_W)'($urandom);
      return d;
   endfunction

   function automatic int near_level(input int level);
      int h, t;
      h = cfg.band_half;
      t = level + $urandom_range(0, 2 * h + 6) - h - 3;
      if (t < 0) t = 0;
      if (t > SAMPLE_MAX) t = SAMPLE_MAX;
      return t;
   endfunction

   function automatic int pick_target(input int grey, input int brown);
      case ($urandom_range(0, 3))
         0: return near_level(grey);
         1: return near_level(brown);
         2: return FULL_SCALE;
         default: return $urandom_range(0, SAMPLE_MAX);
      endcase
   endfunction

   function automatic int sample_near(input int t, input bit exact);
      if (exact || $urandom_range(0, 7) == 0) return t;
      return (t <= 40) ? $urandom_range(0, t) : $urandom_range(t - 40, t);
   endfunction

   task automatic randomise_config();
      int interval;
      case ($urandom_range(0, 9))
         0: interval = 0;
         1: interval = (1 << INTERVAL_W) - 1;
         default: interval = $urandom_range(1, 6);
      endcase
      write_reg(REG_GREY_LEFT, with_junk(pick_level()));
      write_reg(REG_GREY_RIGHT, with_junk(pick_level()));
      write_reg(REG_BROWN_LEFT, with_junk(pick_level()));
      write_reg(REG_BROWN_RIGHT, with_junk(pick_level()));
      case ($urandom_range(0, 4))
         0: write_reg(REG_BAND_HALF, with_junk(0));
         1: write_reg(REG_BAND_HALF, with_junk(FULL_SCALE));
         default: write_reg(REG_BAND_HALF, with_junk($urandom_range(0, 120)));
      endcase
      write_reg(REG_INTERVAL, CSR_DATA_W'(interval));
   endtask

   task automatic test_reset_defaults();
      send_item(MODE_UNUSED, SAMPLE_MAX, SAMPLE_MAX);
      send_item(MODE_TICK, 0, SAMPLE_MAX);
      send_item(MODE_CLEAR, SAMPLE_MAX, 0);
   endtask

   task automatic test_directed_flags();
      wait_idle();
      write_reg(REG_GREY_LEFT, 16'hFC00);
      write_reg(REG_GREY_RIGHT, 200);
      write_reg(REG_BROWN_LEFT, 30);
      write_reg(REG_BROWN_RIGHT, 900);
      write_reg(REG_BAND_HALF, 50);
      write_reg(REG_INTERVAL, 0);
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0001);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_STORE, 40, 180);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_STORE, FULL_SCALE, SAMPLE_MAX);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_STORE, 5, FULL_SCALE);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_STORE, 0, 0);
      send_item(MODE_UNUSED, 0, 0);
      send_item(MODE_TICK, SAMPLE_MAX, SAMPLE_MAX);
   endtask

   task automatic test_interval_extremes();
      wait_idle();
      write_reg(REG_BAND_HALF, 0);
      write_reg(REG_GREY_LEFT, FULL_SCALE);
      write_reg(REG_GREY_RIGHT, FULL_SCALE);
      write_reg(REG_INTERVAL, 16'hFFFF);
      repeat (3) send_item(MODE_TICK, 0, 0);
      wait_idle();
      write_reg(REG_INTERVAL, 2);
      write_reg(REG_BAND_HALF, FULL_SCALE);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_TICK, 0, 0);
      send_item(MODE_TICK, 0, 0);
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      int stores_left;
      int roll;
      bit exact;
      exact = 1'b0;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         if (p == phases - 1) idling = 1'b0;
         randomise_config();
         stores_left = 0;
         for (int n = 0; n < per_phase; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 58) begin
               if (stores_left == 0) begin
                  tgt_left    = pick_target(cfg.grey_left, cfg.brown_left);
                  tgt_right   = pick_target(cfg.grey_right, cfg.brown_right);
                  stores_left = $urandom_range(20, 70);
                  exact       = 1'b1;
               end
               stores_left--;
               send_item(MODE_STORE, sample_near(tgt_left, exact), sample_near(tgt_right, exact));
               exact = 1'b0;
            end else if (roll < 92) begin
               send_item(MODE_TICK, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
            end else if (roll < 96) begin
               send_item(MODE_CLEAR, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
            end else begin
               send_item(MODE_UNUSED, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
            end
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_flags();
      test_interval_extremes();
      test_random_phases(10, 103);
      wait_idle();
      $display("Sent %0d items and checked %0d results, %0d of them window scans,",
               items_sent, reports_checked, scans_run);
      $display("across %0d register writes and %0d cycles.", csr_writes, cycles);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
